>>> rtl/adf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adf_pkg
// Shared types and constants for the averaging deadband filter.
// ----------------------------------------------------------------------------
package adf_pkg;

  localparam int SAMPLE_BITS       = 10;
  localparam int CHANNEL_BITS      = 4;
  localparam int COUNT_BITS        = 8;
  localparam int SUM_BITS          = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_BITS         = $clog2(SUM_BITS);
  localparam int FILTERED_CHANNELS = 4;
  localparam int HELD_IDX_BITS     = (FILTERED_CHANNELS > 1) ? $clog2(FILTERED_CHANNELS) : 1;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 10;

  localparam logic [COUNT_BITS-1:0]    NUM_SAMPLES_RESET = COUNT_BITS'(8);
  localparam logic [SAMPLE_BITS-1:0]   DEADBAND_RESET    = SAMPLE_BITS'(5);
  localparam logic [COUNT_BITS-1:0]    COUNT_MAX         = {COUNT_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0]   SAMPLE_MAX        = {SAMPLE_BITS{1'b1}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_NUM_SAMPLES = 2'd0,
    CFG_DEADBAND    = 2'd1
  } adf_cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_COMPARE
  } adf_state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]  sample_value;
    logic [CHANNEL_BITS-1:0] channel;
  } adf_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]  filtered_value;
    logic [CHANNEL_BITS-1:0] out_channel;
  } adf_out_t;

  typedef struct packed {
    logic                  start;
    logic [SUM_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } adf_div_req_t;

endpackage : adf_pkg
`default_nettype wire

>>> rtl/average_deadband_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// average_deadband_filter
// Block average of converter samples with a per-channel deadband hold.
// ----------------------------------------------------------------------------
// Each accepted sample is added to a running sum. When the
// collected count reaches num_samples (zero counts as one) the sum goes to a
// restoring divider that yields one quotient bit per cycle. A group-ending
// sample keeps the input closed through the divide steps, a step in which
// the divider hands over the quotient and a compare step; only after these
// can the next sample be taken. The compare step is held for as long as the
// output register still carries an uncollected result. A sample that does
// not end a group leaves the input open.
// The quotient saturates at the largest sample value. For the low channels
// the average is compared against that channel's held value: a difference
// below deadband_threshold returns the held value, otherwise the average is
// stored and returned. Other channels pass the average through. The channel
// of the group-ending sample picks the held entry and tags the result. The
// result sits in an output register, so the next sample is taken while a
// result still waits to be collected.
// ----------------------------------------------------------------------------
module average_deadband_filter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // sample requests
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire adf_pkg::adf_in_t                   in_data,
  // result requests
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output adf_pkg::adf_out_t                       out_data,
  // configuration requests
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [adf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [adf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import adf_pkg::*;

  // configuration registers
  logic [COUNT_BITS-1:0]   num_samples;
  logic [SAMPLE_BITS-1:0]  deadband_threshold;

  // accumulation state
  logic [SUM_BITS-1:0]     sample_sum;
  logic [COUNT_BITS-1:0]   sample_count;
  logic [SAMPLE_BITS-1:0]  held_value [FILTERED_CHANNELS];

  adf_state_t              state, state_next;
  logic [CHANNEL_BITS-1:0] group_channel;

  logic                    in_take;
  logic [SUM_BITS-1:0]     sum_next;
  logic [COUNT_BITS-1:0]   count_next;
  logic [COUNT_BITS-1:0]   n_eff;
  logic                    group_end;

  adf_div_req_t            div_req;
  logic [SUM_BITS-1:0]     quotient;
  logic                    div_done;

  logic [SAMPLE_BITS-1:0]  avg;
  logic [SAMPLE_BITS-1:0]  prev;
  logic [SAMPLE_BITS-1:0]  diff;
  logic                    filtered;
  logic                    keep_prev;
  logic                    out_free;
  logic                    publish;
  logic [HELD_IDX_BITS-1:0] held_idx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_take   = in_valid && in_ready;

  // running sum and saturating count, group end test
  always_comb begin
    n_eff      = (num_samples == '0) ? COUNT_BITS'(1) : num_samples;
    sum_next   = sample_sum + SUM_BITS'(in_data.sample_value);
    count_next = (sample_count < COUNT_MAX) ? sample_count + COUNT_BITS'(1) : sample_count;
    group_end  = count_next >= n_eff;
  end

  always_comb begin
    div_req.start    = in_take && group_end;
    div_req.dividend = sum_next;
    div_req.divisor  = n_eff;
  end

  adf_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .quotient (quotient),
    .done     (div_done)
  );

  // deadband compare on the saturated quotient
  always_comb begin
    avg       = (|quotient[SUM_BITS-1:SAMPLE_BITS]) ? SAMPLE_MAX : quotient[SAMPLE_BITS-1:0];
    filtered  = 32'(group_channel) < FILTERED_CHANNELS;
    held_idx  = group_channel[HELD_IDX_BITS-1:0];
    prev      = held_value[held_idx];
    diff      = (avg > prev) ? avg - prev : prev - avg;
    keep_prev = filtered && (diff < deadband_threshold);
    out_free  = !out_valid || out_ready;
    publish   = (state == ST_COMPARE) && out_free;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (div_req.start) state_next = ST_DIVIDE;
      ST_DIVIDE:  if (div_done) state_next = ST_COMPARE;
      ST_COMPARE: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes, indexes beyond the list fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples        <= NUM_SAMPLES_RESET;
      deadband_threshold <= DEADBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_SAMPLES: num_samples        <= cfg_data[COUNT_BITS-1:0];
        CFG_DEADBAND:    deadband_threshold <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (in_take) begin
      sample_sum   <= group_end ? '0 : sum_next;
      sample_count <= group_end ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && group_end) begin
      group_channel <= in_data.channel;
    end
  end

  // held values per filtered channel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILTERED_CHANNELS; i++) begin
        held_value[i] <= '0;
      end
    end else if (publish && filtered && !keep_prev) begin
      held_value[held_idx] <= avg;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_data.filtered_value <= keep_prev ? prev : avg;
      out_data.out_channel    <= group_channel;
    end
  end

endmodule : average_deadband_filter
`default_nettype wire

>>> rtl/adf_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adf_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adf_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire adf_pkg::adf_div_req_t          req,
  output logic [adf_pkg::SUM_BITS-1:0]        quotient,
  output logic                                done
);
  import adf_pkg::*;

  logic                   busy;
  logic [STEP_BITS-1:0]   step;
  logic [COUNT_BITS-1:0]  rem;
  logic [COUNT_BITS-1:0]  divisor;
  logic [SUM_BITS-1:0]    dq;

  logic [COUNT_BITS:0]    shifted;
  logic                   fits;
  logic [COUNT_BITS:0]    diff;

  always_comb begin
    shifted = {rem, dq[SUM_BITS-1]};
    fits    = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_BITS'(1);
        if (step == STEP_BITS'(SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      dq      <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
      dq  <= {dq[SUM_BITS-2:0], fits};
    end
  end

  assign quotient = dq;

endmodule : adf_divider
`default_nettype wire

>>> verif/adf_result_check.sv
// ----------------------------------------------------------------------------
// adf_result_check
// Watches the sample, result and register channels of the averaging deadband
// filter. It keeps its own running sum, count, held values and register
// copies, works out the average each group-ending sample should give, and
// compares every collected result field by field in order.
// ----------------------------------------------------------------------------
module adf_result_check (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  adf_pkg::adf_in_t                   in_data,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  adf_pkg::adf_out_t                  out_data,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [adf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [adf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                 errors,
  output int                                 awaiting,
  output int                                 averages_checked,
  output int                                 holds_predicted
);
  import adf_pkg::*;

  logic [COUNT_BITS-1:0]  group_len;
  logic [SAMPLE_BITS-1:0] band;
  logic [SAMPLE_BITS-1:0] held [FILTERED_CHANNELS];
  int unsigned            run_sum;
  int unsigned            run_count;
  adf_out_t               averages_due [$];
  int                     error_tally;
  int                     checked_tally;
  int                     hold_tally;

  // add one sample; a group-ending sample queues the average it produces
  task automatic absorb_sample(input adf_in_t s);
    int unsigned n;
    int unsigned avg;
    int unsigned prev;
    int unsigned gap;
    adf_out_t    res;
    n = (group_len == '0) ? 1 : group_len;
    run_sum += 32'(s.sample_value);
    if (run_count < COUNT_MAX) run_count++;
    if (run_count < n) return;
    avg = run_sum / n;
    if (avg > SAMPLE_MAX) avg = 32'(SAMPLE_MAX);
    run_sum = 0;
    run_count = 0;
    if (s.channel < FILTERED_CHANNELS) begin
      prev = 32'(held[s.channel[HELD_IDX_BITS-1:0]]);
      gap = (avg > prev) ? avg - prev : prev - avg;
      if (gap < band) begin
        avg = prev;
        hold_tally++;
      end else begin
        held[s.channel[HELD_IDX_BITS-1:0]] = SAMPLE_BITS'(avg);
      end
    end
    res.filtered_value = SAMPLE_BITS'(avg);
    res.out_channel = s.channel;
    averages_due.push_back(res);
  endtask

  always @(posedge clk) begin : watch
    adf_out_t want;
    if (rst) begin
      group_len = NUM_SAMPLES_RESET;
      band = DEADBAND_RESET;
      for (int i = 0; i < FILTERED_CHANNELS; i++) held[i] = '0;
      run_sum = 0;
      run_count = 0;
      averages_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (averages_due.size() == 0) begin
          $display("%0t: result with none awaited: expected none, got value %0d channel %0d",
                   $time, out_data.filtered_value, out_data.out_channel);
          error_tally++;
        end else begin
          want = averages_due.pop_front();
          checked_tally++;
          if (out_data.filtered_value !== want.filtered_value) begin
            $display("%0t: filtered_value mismatch: expected %0d, got %0d",
                     $time, want.filtered_value, out_data.filtered_value);
            error_tally++;
          end
          if (out_data.out_channel !== want.out_channel) begin
            $display("%0t: out_channel mismatch: expected %0d, got %0d",
                     $time, want.out_channel, out_data.out_channel);
            error_tally++;
          end
        end
      end
      // a sample taken at the same edge still sees the old registers
      if (in_valid && in_ready) absorb_sample(in_data);
      if (cfg_valid && cfg_ready) begin
        case (adf_cfg_index_t'(cfg_index))
          CFG_NUM_SAMPLES: group_len = cfg_data[COUNT_BITS-1:0];
          CFG_DEADBAND:    band = cfg_data[SAMPLE_BITS-1:0];
          default:         ;
        endcase
      end
    end
    errors <= error_tally;
    awaiting <= averages_due.size();
    averages_checked <= checked_tally;
    holds_predicted <= hold_tally;
  end

endmodule : adf_result_check

>>> verif/average_deadband_filter_tb.sv
// ----------------------------------------------------------------------------
// average_deadband_filter_tb
// Stimulus and verdict for the averaging deadband filter.
// ----------------------------------------------------------------------------
// A short directed run covers the reset settings, single-sample groups,
// hold and update on either side of the deadband, pass-through channels,
// zero and full-scale deadband, mixed channels in a group, writes to unused
// register indexes and a group shortened mid-way so the quotient saturates.
// Random phases then sweep several register settings with mostly
// well-formed groups around a drifting level, plus stray channels and
// full-range samples. Sender and receiver idle at random, and once the
// receiver holds off long enough for the input to back up.
// ----------------------------------------------------------------------------
module average_deadband_filter_tb;
  import adf_pkg::*;

  localparam int DRAIN_CYCLES = 30;    // group end: divide and compare, with margin
  localparam int HOLD_OFF     = 400;   // long receiver stall
  localparam int QUIET_LIMIT  = 5000;  // cycles with no request moving

  // indexes past the end of the register map, to be ignored
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  adf_in_t                   in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  adf_out_t                  out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  int errors;
  int awaiting;
  int averages_checked;
  int holds_predicted;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit stall_arm   = 1'b0;
  bit stall_done  = 1'b0;
  int hold_left   = 0;
  int quiet       = 0;
  int samples_sent = 0;
  int settings_used = 1;   // reset values count as the first

  // random group generator state
  int                      level    = 512;
  int                      grp_left = 0;
  logic [CHANNEL_BITS-1:0] grp_chan = '0;

  average_deadband_filter uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  adf_result_check scoreboard (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .awaiting         (awaiting),
    .averages_checked (averages_checked),
    .holds_predicted  (holds_predicted)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random back-pressure, plus one long hold-off that starts
  // on a taken sample so the sender keeps offering during it
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_arm && !stall_done && in_valid && in_ready) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_OFF;
      stall_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // watchdog: any request moving on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog: no request moved for %0d cycles", $time, quiet);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] clip(input int x);
    if (x < 0) return '0;
    if (x > SAMPLE_MAX) return SAMPLE_MAX;
    return SAMPLE_BITS'(x);
  endfunction

  // offer one sample, maybe after a random gap; valid stays up afterwards
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] v,
                             input logic [CHANNEL_BITS-1:0] ch);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= '{sample_value: v, channel: ch};
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // register write; 'more' keeps valid up for a write straight after
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // stop offering, let every awaited result out, then give a
  // non-ending sample time to finish before registers change
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one random phase at a given group length and deadband
  task automatic run_phase(input logic [COUNT_BITS-1:0] len,
                           input logic [SAMPLE_BITS-1:0] th,
                           input int items);
    int                      n_eff;
    int                      pick;
    logic [SAMPLE_BITS-1:0]  v;
    logic [CHANNEL_BITS-1:0] ch;
    settle();
    // spare upper bits of the group length write must be dropped
    write_reg(CFG_NUM_SAMPLES, {2'($urandom), len}, 1'b1);
    write_reg(CFG_DEADBAND, th, 1'b0);
    settings_used++;
    n_eff = (len == '0) ? 1 : len;
    grp_left = 0;
    for (int i = 0; i < items; i++) begin
      if (grp_left == 0) begin
        // new group: mostly a filtered channel, level drifting around the band
        grp_left = n_eff;
        pick = $urandom_range(0, 99);
        grp_chan = (pick < 85) ? CHANNEL_BITS'($urandom_range(0, FILTERED_CHANNELS - 1))
                               : CHANNEL_BITS'($urandom_range(0, 15));
        if (pick % 10 == 0)
          level = $urandom_range(0, SAMPLE_MAX);
        else if (pick % 2 == 0)
          level = int'(clip(level + int'($urandom_range(0, 2 * th + 2)) - int'(th) - 1));
      end
      grp_left--;
      pick = $urandom_range(0, 99);
      if (pick < 8)
        v = (pick % 2 != 0) ? SAMPLE_MAX : '0;
      else if (pick < 20)
        v = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      else
        v = clip(level + int'($urandom_range(0, 2)) - 1);
      // stray channel now and then breaks the group's channel
      ch = ($urandom_range(0, 99) < 8) ? CHANNEL_BITS'($urandom_range(0, 15)) : grp_chan;
      push_sample(v, ch);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 14;
    rx_idle_pct <= 65;

    // reset settings: group of eight, deadband five, channel 1 moves off zero
    for (int i = 0; i < 8; i++) push_sample((i % 2 == 0) ? SAMPLE_MAX : '0, 4'd1);

    // group length zero acts as one (upper data bits must be dropped);
    // writes past the register map must change nothing
    settle();
    write_reg(CFG_NUM_SAMPLES, 10'h300, 1'b1);
    write_reg(CFG_SPARE_A, 10'h3FF, 1'b1);
    write_reg(CFG_SPARE_B, 10'h000, 1'b0);
    settings_used++;
    push_sample(10'd1023, 4'd0);   // full scale stored
    push_sample(10'd1020, 4'd0);   // three below: held
    push_sample(10'd508, 4'd1);    // three below the held 511: held
    push_sample(10'd516, 4'd1);    // exactly the band away: stored
    push_sample(10'd1023, 4'd15);  // unfiltered channel passes through
    push_sample(10'd0, 4'd3);      // equal to held zero: held

    // zero deadband: even an equal average is stored
    settle();
    write_reg(CFG_DEADBAND, 10'd0, 1'b0);
    settings_used++;
    push_sample(10'd0, 4'd3);
    push_sample(10'd516, 4'd1);

    // full-scale deadband, groups of two; channel of the last sample decides
    settle();
    write_reg(CFG_DEADBAND, 10'd1023, 1'b1);
    write_reg(CFG_NUM_SAMPLES, 10'd2, 1'b0);
    settings_used++;
    push_sample(10'd100, 4'd7);
    push_sample(10'd200, 4'd2);
    push_sample(10'd1023, 4'd2);   // difference of 1023 is not below the band
    push_sample(10'd1023, 4'd2);

    // three samples into a group of four, then the length drops to one:
    // the next sample ends the group and the quotient saturates
    settle();
    write_reg(CFG_NUM_SAMPLES, 10'd4, 1'b0);
    settings_used++;
    for (int i = 0; i < 3; i++) push_sample(10'd1023, 4'd9);
    settle();
    write_reg(CFG_NUM_SAMPLES, 10'h101, 1'b0);
    settings_used++;
    push_sample(10'd1023, 4'd9);

    // random phases, sender idling lightly and receiver heavily; the
    // single-sample phase also gets the long receiver hold-off
    stall_arm <= 1'b1;
    run_phase(8'd1, 10'd0, 30);
    run_phase(8'd3, 10'd5, 45);
    run_phase(8'd16, 10'd20, 48);

    // sender idles heavily, receiver lightly; longest groups here
    settle();
    tx_idle_pct = 65;
    rx_idle_pct <= 14;
    run_phase(8'd255, 10'd3, 255);
    run_phase(8'd2, 10'd1023, 30);
    run_phase(8'd7, 10'd1, 42);

    // no idling on either side
    settle();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_phase(8'd4, 10'd10, 40);
    run_phase(8'd0, 10'd2, 30);

    settle();
    $display("%0d samples over %0d register settings gave %0d averages, %0d of them held",
             samples_sent, settings_used, averages_checked, holds_predicted);
    $display("back-pressure ran at several rates, with one long output stall");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : average_deadband_filter_tb
